// ===== hw/rtl/hsv_to_rgb_pixel_converter_top_macros.svh =====
// ---------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion wrappers for the converter checker.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_TOP_MACROS_SVH

// Checked only while out of reset.
`define HSV2RGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HSV2RGB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hsv2rgb_pkg.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, stream packing and hue sector constants.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W       = 15;
  localparam int CH_W        = 9;
  localparam int IN_TDATA_W  = 40;  // 33 field bits, padded to bytes
  localparam int OUT_TDATA_W = 32;  // 27 field bits, padded to bytes
  localparam int OUT_FLD_W   = 3 * CH_W;

  // One sector is 60 degrees = 3840 hue steps = 15 * 2^SEC_LOG2.
  localparam int SEC_LOG2     = 8;
  localparam int SECTOR_STEPS = 15 << SEC_LOG2;
  localparam int FULL_TURN    = 6 * SECTOR_STEPS;
  localparam int REM_W        = 12;

  localparam logic [2:0] SEC_R_Y = 3'd0;
  localparam logic [2:0] SEC_Y_G = 3'd1;
  localparam logic [2:0] SEC_G_C = 3'd2;
  localparam logic [2:0] SEC_C_B = 3'd3;
  localparam logic [2:0] SEC_B_M = 3'd4;
  localparam logic [2:0] SEC_M_R = 3'd5;

endpackage

// ===== hw/rtl/hsv_to_rgb_pixel_converter_top.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB pixel converter
// Six-stage pipeline turning one fixed-point HSV color into one RGB color.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : stream slave. One transfer carries one color: hue in degrees
//           times 64 (0..23039, larger codes wrap once), sat and val with
//           2^FRAC_BITS meaning 1.0 (larger codes clamp to 1.0).
//   out_* : stream master. One transfer per input transfer, same order,
//           red/green/blue in the same fixed-point format, 9 bits each.
//   Throughput: one color per cycle while the output is not stalled; the
//   six register stages move together and each stage is at most one
//   multiply deep (or the hue wrap / sector compare).
//   Reset clears the stage valid bits only; the pipe comes up empty.
//   Stall: when out_tvalid is high and out_tready low the whole pipe
//   freezes, in_tready drops in the same cycle, and nothing is lost or
//   repeated. While the output slot is empty or being drained, in_tready
//   stays high.
//   FRAC_BITS (6..16) sets the internal fraction width; the port widths
//   are fixed and results are truncated to 9 bits.
// ---------------------------------------------------------------------------
module hsv_to_rgb_pixel_converter_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [14:0] hue, [23:15] sat, [32:24] val, [39:33] zero
  input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [8:0] red, [17:9] green, [26:18] blue, [31:27] zero
  output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hsv2rgb_pkg::*;

  localparam int NSTG = 6;
  localparam int UW   = FRAC_BITS + 1;          // unit range 0..ONE
  localparam int MW2  = 2 * UW;                 // product width
  localparam int IW   = (UW > CH_W) ? UW : CH_W; // clamp compare width
  // f = rem * 2^F / (15 * 2^SEC_LOG2): scale up or down by a power of two,
  // divide by 15 through a reciprocal multiply.
  localparam int SH   = (FRAC_BITS > SEC_LOG2) ? FRAC_BITS - SEC_LOG2 : 0;
  localparam int RS   = (FRAC_BITS < SEC_LOG2) ? SEC_LOG2 - FRAC_BITS : 0;
  localparam int XW   = REM_W + SH;
  localparam int KR   = XW + 4;                 // reciprocal exact for x < 2^KR/14
  localparam int MW   = KR - 3;
  localparam int PW   = XW + MW;
  localparam logic [MW-1:0]    RECIP = MW'((64'd1 << KR) / 64'd15 + 64'd1);
  localparam logic [UW-1:0]    ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IW-1:0]    ONE_I = IW'(ONE);
  localparam logic [HUE_W-1:0] TURN  = HUE_W'(FULL_TURN);

  // Global advance: pipe moves whenever the output slot can take data.
  logic            adv;
  logic [NSTG-1:0] vld_r, vld_nxt;

  assign adv        = out_tready || !vld_r[NSTG-1];
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NSTG-1];
  assign vld_nxt    = {vld_r[NSTG-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---- Stage 1: hue wrap, sat/val clamp
  logic [HUE_W-1:0] in_hue;
  logic [IW-1:0]    in_sat_i, in_val_i;
  logic [HUE_W-1:0] s1_hue_r, s1_hue_nxt;
  logic [UW-1:0]    s1_sat_r, s1_sat_nxt, s1_val_r, s1_val_nxt;

  assign in_hue     = in_tdata[HUE_W-1:0];
  assign in_sat_i   = IW'(in_tdata[HUE_W +: CH_W]);
  assign in_val_i   = IW'(in_tdata[HUE_W+CH_W +: CH_W]);
  assign s1_hue_nxt = (in_hue >= TURN) ? in_hue - TURN : in_hue;
  assign s1_sat_nxt = UW'((in_sat_i > ONE_I) ? ONE_I : in_sat_i);
  assign s1_val_nxt = UW'((in_val_i > ONE_I) ? ONE_I : in_val_i);

  // ---- Stage 2: sector and remainder, 1 - s
  logic [2:0]       s2_sec_r, s2_sec_nxt;
  logic [HUE_W-1:0] sec_base;
  logic [REM_W-1:0] s2_rem_r, s2_rem_nxt;
  logic [UW-1:0]    s2_sat_r, s2_val_r, s2_ns_r, s2_ns_nxt;

  always_comb begin
    if (s1_hue_r < HUE_W'(SECTOR_STEPS)) begin
      s2_sec_nxt = SEC_R_Y;
    end else if (s1_hue_r < HUE_W'(2 * SECTOR_STEPS)) begin
      s2_sec_nxt = SEC_Y_G;
    end else if (s1_hue_r < HUE_W'(3 * SECTOR_STEPS)) begin
      s2_sec_nxt = SEC_G_C;
    end else if (s1_hue_r < HUE_W'(4 * SECTOR_STEPS)) begin
      s2_sec_nxt = SEC_C_B;
    end else if (s1_hue_r < HUE_W'(5 * SECTOR_STEPS)) begin
      s2_sec_nxt = SEC_B_M;
    end else begin
      s2_sec_nxt = SEC_M_R;
    end
  end

  always_comb begin
    case (s2_sec_nxt)
      SEC_R_Y: sec_base = '0;
      SEC_Y_G: sec_base = HUE_W'(SECTOR_STEPS);
      SEC_G_C: sec_base = HUE_W'(2 * SECTOR_STEPS);
      SEC_C_B: sec_base = HUE_W'(3 * SECTOR_STEPS);
      SEC_B_M: sec_base = HUE_W'(4 * SECTOR_STEPS);
      default: sec_base = HUE_W'(5 * SECTOR_STEPS);
    endcase
  end

  assign s2_rem_nxt = REM_W'(s1_hue_r - sec_base);
  assign s2_ns_nxt  = ONE - s1_sat_r;

  // ---- Stage 3: fraction f, p = v(1-s)
  logic [XW-1:0]        rem_x;
  logic [PW-1:0]        f_prod;
  logic [MW2-1:0]       p_prod;
  logic [FRAC_BITS-1:0] s3_f_r, s3_f_nxt;
  logic [UW-1:0]        s3_p_r, s3_p_nxt, s3_sat_r, s3_val_r;
  logic [2:0]           s3_sec_r;

  assign rem_x    = XW'(s2_rem_r) << SH;
  assign f_prod   = PW'(rem_x) * PW'(RECIP);
  assign s3_f_nxt = FRAC_BITS'(f_prod >> (KR + RS));
  assign p_prod   = MW2'(s2_val_r) * MW2'(s2_ns_r);
  assign s3_p_nxt = p_prod[FRAC_BITS +: UW];

  // ---- Stage 4: s*f and s*(1-f)
  logic [MW2-1:0] sf_prod, sfc_prod;
  logic [UW-1:0]  s4_sf_r, s4_sf_nxt, s4_sfc_r, s4_sfc_nxt;
  logic [UW-1:0]  s4_p_r, s4_val_r;
  logic [2:0]     s4_sec_r;

  assign sf_prod    = MW2'(s3_sat_r) * MW2'(s3_f_r);
  assign sfc_prod   = MW2'(s3_sat_r) * MW2'(ONE - UW'(s3_f_r));
  assign s4_sf_nxt  = sf_prod[FRAC_BITS +: UW];
  assign s4_sfc_nxt = sfc_prod[FRAC_BITS +: UW];

  // ---- Stage 5: q = v(1-sf), t = v(1-s(1-f))
  logic [MW2-1:0] q_prod, t_prod;
  logic [UW-1:0]  s5_q_r, s5_q_nxt, s5_t_r, s5_t_nxt, s5_p_r, s5_val_r;
  logic [2:0]     s5_sec_r;

  assign q_prod   = MW2'(s4_val_r) * MW2'(ONE - s4_sf_r);
  assign t_prod   = MW2'(s4_val_r) * MW2'(ONE - s4_sfc_r);
  assign s5_q_nxt = q_prod[FRAC_BITS +: UW];
  assign s5_t_nxt = t_prod[FRAC_BITS +: UW];

  // ---- Stage 6: sector select into output register
  logic [UW-1:0]   r_sel, g_sel, b_sel;
  logic [CH_W-1:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  always_comb begin
    case (s5_sec_r)
      SEC_R_Y: begin r_sel = s5_val_r; g_sel = s5_t_r;   b_sel = s5_p_r;   end
      SEC_Y_G: begin r_sel = s5_q_r;   g_sel = s5_val_r; b_sel = s5_p_r;   end
      SEC_G_C: begin r_sel = s5_p_r;   g_sel = s5_val_r; b_sel = s5_t_r;   end
      SEC_C_B: begin r_sel = s5_p_r;   g_sel = s5_q_r;   b_sel = s5_val_r; end
      SEC_B_M: begin r_sel = s5_t_r;   g_sel = s5_p_r;   b_sel = s5_val_r; end
      default: begin r_sel = s5_val_r; g_sel = s5_p_r;   b_sel = s5_q_r;   end
    endcase
  end

  assign red_nxt   = CH_W'(r_sel);
  assign green_nxt = CH_W'(g_sel);
  assign blue_nxt  = CH_W'(b_sel);

  // Payload registers, no reset; all gated by the common advance.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hue_r <= s1_hue_nxt;
      s1_sat_r <= s1_sat_nxt;
      s1_val_r <= s1_val_nxt;

      s2_sec_r <= s2_sec_nxt;
      s2_rem_r <= s2_rem_nxt;
      s2_sat_r <= s1_sat_r;
      s2_val_r <= s1_val_r;
      s2_ns_r  <= s2_ns_nxt;

      s3_f_r   <= s3_f_nxt;
      s3_p_r   <= s3_p_nxt;
      s3_sat_r <= s2_sat_r;
      s3_val_r <= s2_val_r;
      s3_sec_r <= s2_sec_r;

      s4_sf_r  <= s4_sf_nxt;
      s4_sfc_r <= s4_sfc_nxt;
      s4_p_r   <= s3_p_r;
      s4_val_r <= s3_val_r;
      s4_sec_r <= s3_sec_r;

      s5_q_r   <= s5_q_nxt;
      s5_t_r   <= s5_t_nxt;
      s5_p_r   <= s4_p_r;
      s5_val_r <= s4_val_r;
      s5_sec_r <= s4_sec_r;

      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
    end
  end

  assign out_tdata = {(OUT_TDATA_W - OUT_FLD_W)'(0), blue_r, green_r, red_r};

endmodule

// ===== hw/rtl/hsv2rgb_checker.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB converter port checker
// Port-level properties of the converter, bound onto the top level.
// ---------------------------------------------------------------------------
`include "hsv_to_rgb_pixel_converter_top_macros.svh"

module hsv2rgb_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [hsv2rgb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hsv2rgb_pkg::*;

  logic out_stall;
  logic out_free;
  logic pad_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign out_free  = out_tready || !out_tvalid;
  assign pad_ok    = (out_tdata[OUT_TDATA_W-1:OUT_FLD_W] == '0);

  // Stalled result holds until taken.
  `HSV2RGB_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "stall lost data")

  // Pipe comes out of reset empty.
  `HSV2RGB_ASSERT_RST(a_rst_empty, $past(!rst_n) |-> !out_tvalid, "valid out of reset")

  // Input side only waits on a full, stalled output slot.
  `HSV2RGB_ASSERT(a_in_ready, out_free |-> in_tready, "in_tready low with output slot free")

  // Padding above blue stays zero.
  `HSV2RGB_ASSERT(a_pad_zero, out_tvalid |-> pad_ok, "nonzero tdata padding")

endmodule

bind hsv_to_rgb_pixel_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);

// ===== tb/sv/tb_hsv_to_rgb_pixel_converter_top.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB pixel converter testbench
// Drives colors into the stream slave with random gaps, stalls the stream
// master at random, and compares every output color against an in-bench
// fixed-point converter, in order.
// ---------------------------------------------------------------------------
module tb_hsv_to_rgb_pixel_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int FRAC = 8;
  localparam int unsigned ONE = 1 << FRAC;
  // Longest quiet stretch: a long sender gap plus a long receiver stall
  // plus the six pipeline stages stays far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_COLORS = 550;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Expected colors in arrival order, plus the converter that makes them.
  class hsv_color_board;
    rgb_t expected_rgb[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function rgb_t convert(logic [HUE_W-1:0] hue_in, logic [CH_W-1:0] sat_in,
                           logic [CH_W-1:0] val_in);
      int unsigned h, s, v, sec, f, p, q, t;
      rgb_t c;
      h = 32'(hue_in);
      // Codes past a full turn wrap once.
      if (h >= FULL_TURN) h = h - FULL_TURN;
      // Saturation and value clamp to 1.0.
      s = (32'(sat_in) > ONE) ? ONE : 32'(sat_in);
      v = (32'(val_in) > ONE) ? ONE : 32'(val_in);
      sec = h / SECTOR_STEPS;
      f = ((h % SECTOR_STEPS) * ONE) / SECTOR_STEPS;
      p = (v * (ONE - s)) >> FRAC;
      q = (v * (ONE - ((s * f) >> FRAC))) >> FRAC;
      t = (v * (ONE - ((s * (ONE - f)) >> FRAC))) >> FRAC;
      case (sec[2:0])
        SEC_R_Y: begin c.red = CH_W'(v); c.green = CH_W'(t); c.blue = CH_W'(p); end
        SEC_Y_G: begin c.red = CH_W'(q); c.green = CH_W'(v); c.blue = CH_W'(p); end
        SEC_G_C: begin c.red = CH_W'(p); c.green = CH_W'(v); c.blue = CH_W'(t); end
        SEC_C_B: begin c.red = CH_W'(p); c.green = CH_W'(q); c.blue = CH_W'(v); end
        SEC_B_M: begin c.red = CH_W'(t); c.green = CH_W'(p); c.blue = CH_W'(v); end
        default: begin c.red = CH_W'(v); c.green = CH_W'(p); c.blue = CH_W'(q); end
      endcase
      return c;
    endfunction

    function void note_hsv(logic [IN_TDATA_W-1:0] data);
      expected_rgb.push_back(convert(data[HUE_W-1:0], data[HUE_W+CH_W-1:HUE_W],
                                     data[HUE_W+2*CH_W-1:HUE_W+CH_W]));
    endfunction

    function void check_rgb(logic [OUT_TDATA_W-1:0] data);
      rgb_t exp_c, act_c;
      act_c.red   = data[CH_W-1:0];
      act_c.green = data[2*CH_W-1:CH_W];
      act_c.blue  = data[3*CH_W-1:2*CH_W];
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected output color r=%0d g=%0d b=%0d",
                 $time, act_c.red, act_c.green, act_c.blue);
        mismatches++;
        return;
      end
      exp_c = expected_rgb.pop_front();
      if (act_c.red !== exp_c.red) begin
        $display("%0t: red mismatch, expected %0d, actual %0d", $time, exp_c.red, act_c.red);
        mismatches++;
      end
      if (act_c.green !== exp_c.green) begin
        $display("%0t: green mismatch, expected %0d, actual %0d",
                 $time, exp_c.green, act_c.green);
        mismatches++;
      end
      if (act_c.blue !== exp_c.blue) begin
        $display("%0t: blue mismatch, expected %0d, actual %0d", $time, exp_c.blue, act_c.blue);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // [14:0] hue, [23:15] sat, [32:24] val, rest zero
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata; // [8:0] red, [17:9] green, [26:18] blue, rest zero

  hsv_color_board board = new();
  bit steady_flow;   // when set, neither side idles
  int quiet_cycles;

  hsv_to_rgb_pixel_converter_top #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One color transfer. Called at a falling edge; returns at a falling edge
  // with in_tvalid still high if the next transfer follows back to back.
  task automatic send_hsv(int unsigned hue, int unsigned sat, int unsigned val);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, val[CH_W-1:0], sat[CH_W-1:0], hue[HUE_W-1:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Receiver: runs of ready with random stalls between them.
  task automatic drive_out_ready();
    int stall;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  endtask

  // Transfers are taken from the values settled before each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_hsv(in_tdata);
      if (out_tvalid && out_tready) board.check_rgb(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("** hsv_to_rgb_pixel_converter_top: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned hue, sat, val;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    steady_flow = 1'b0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    fork
      drive_out_ready();
    join_none

    // Directed: sector edges at full color, wrap codes, clamps, zeros.
    send_hsv(0, 256, 256);
    send_hsv(3839, 256, 256);
    send_hsv(3840, 256, 256);
    send_hsv(7679, 256, 256);
    send_hsv(7680, 256, 256);
    send_hsv(11520, 256, 256);
    send_hsv(15360, 256, 256);
    send_hsv(19200, 256, 256);
    send_hsv(21000, 256, 256);
    send_hsv(23039, 256, 256);
    send_hsv(23040, 256, 256);   // exactly a full turn
    send_hsv(32767, 511, 511);   // top of every field
    send_hsv(1920, 0, 256);      // gray
    send_hsv(1920, 256, 0);      // black
    send_hsv(0, 0, 0);
    send_hsv(9000, 257, 200);    // saturation above one
    send_hsv(13000, 200, 300);   // value above one
    send_hsv(17000, 511, 1);
    send_hsv(5000, 128, 200);
    send_hsv(25000, 100, 255);

    // Random: each phase is either gappy or a steady stream, picked at random.
    for (int i = 0; i < RANDOM_COLORS; i++) begin
      if (i % 110 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 8) begin
        hue = $urandom_range(0, FULL_TURN - 1);
        sat = $urandom_range(0, ONE);
        val = $urandom_range(0, ONE);
      end else begin
        hue = $urandom_range(0, (1 << HUE_W) - 1);
        sat = $urandom_range(0, (1 << CH_W) - 1);
        val = $urandom_range(0, (1 << CH_W) - 1);
      end
      send_hsv(hue, sat, val);
    end
    in_tvalid <= 1'b0;

    // Drain, then give stray outputs a chance to show up.
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("** hsv_to_rgb_pixel_converter_top: PASSED **");
    else
      $display("** hsv_to_rgb_pixel_converter_top: FAILED **");
    $finish;
  end

endmodule
